### src/framed_led_breathing_ramp_defines.svh
// assertion macros shared by the ramp controller files
`ifndef FRAMED_LED_BREATHING_RAMP_DEFINES_SVH
`define FRAMED_LED_BREATHING_RAMP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define FBLR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define FBLR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/fblr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fblr_pkg
// Types and constants for the framed breathing-LED ramp controller.
// ----------------------------------------------------------------------------
package fblr_pkg;

    // item kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // ramp modes
    localparam logic [1:0] MODE_RISING  = 2'd0;
    localparam logic [1:0] MODE_FALLING = 2'd1;
    localparam logic [1:0] MODE_DARK    = 2'd2;

    // frame commands
    localparam logic [7:0] CMD_RESTART = 8'd1;
    localparam logic [7:0] CMD_FALL    = 8'd2;
    localparam logic [7:0] CMD_DARK    = 8'd4;

    // frame start mark
    localparam logic [7:0] START_MARK = 8'd255;

    // ramp arithmetic
    localparam logic [16:0] STEP_SIZE  = 17'd1000;
    localparam logic [15:0] BOUND_MULT = 16'd39;
    localparam logic [15:0] TOP_MULT   = 16'd40;
    localparam logic [15:0] TOP_RESET  = 16'd39999;
    localparam logic [9:0]  UNIT_RESET = 10'd1000;

    // input beat
    typedef struct packed {
        logic       command;
        logic [7:0] byte_value;
    } item_t;

    // result beat
    typedef struct packed {
        logic [15:0] duty;
        logic [15:0] pwm_top;
        logic [1:0]  mode;
        logic        frame_done;
        logic        frame_accepted;
    } result_t;

    // update request from the frame logic to the ramp
    typedef struct packed {
        logic       tick;
        logic       apply;
        logic [7:0] cmd;
        logic [7:0] data;
    } ramp_ctl_t;

    // ramp state after the update
    typedef struct packed {
        logic [15:0] duty;
        logic [15:0] pwm_top;
        logic [1:0]  mode;
    } ramp_view_t;

endpackage

### src/fblr_ramp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fblr_ramp
// Duty ramp state: steps on ticks, reloads on accepted frames, reverses at
// the bounds and reports its post-update values.
// ----------------------------------------------------------------------------
`include "framed_led_breathing_ramp_defines.svh"

module fblr_ramp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  fblr_pkg::ramp_ctl_t   ctl,
    output fblr_pkg::ramp_view_t  view
);

    logic [1:0]  mode_reg, mode_next;
    logic [16:0] duty_reg, duty_next;
    logic [9:0]  unit_reg, unit_next;
    logic [15:0] top_reg, top_next;

    logic [15:0] bound;
    logic [16:0] duty_step;
    logic        at_top;

    // upper bound from the current period unit
    assign bound = {6'b0, unit_reg} * fblr_pkg::BOUND_MULT;

    // duty after one tick step
    always_comb
    begin
        case (mode_reg)
            fblr_pkg::MODE_RISING:  duty_step = duty_reg + fblr_pkg::STEP_SIZE;
            fblr_pkg::MODE_FALLING: duty_step = duty_reg - fblr_pkg::STEP_SIZE;
            fblr_pkg::MODE_DARK:    duty_step = 17'd0;
            default:                duty_step = duty_reg;
        endcase
    end

    assign at_top = $signed({duty_step[16], duty_step}) >= $signed({2'b00, bound});

    // next state
    always_comb
    begin
        mode_next = mode_reg;
        duty_next = duty_reg;
        unit_next = unit_reg;
        top_next  = top_reg;
        if (ctl.apply)
        begin
            case (ctl.cmd)
                fblr_pkg::CMD_RESTART:
                begin
                    mode_next = fblr_pkg::MODE_RISING;
                    duty_next = 17'd0;
                end
                fblr_pkg::CMD_FALL:
                begin
                    mode_next = fblr_pkg::MODE_FALLING;
                    duty_next = {1'b0, bound};
                end
                fblr_pkg::CMD_DARK:
                begin
                    mode_next = fblr_pkg::MODE_DARK;
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
            unit_next = {ctl.data, 2'b00};
            top_next  = {6'b0, unit_next} * fblr_pkg::TOP_MULT;
        end
        else if (ctl.tick)
        begin
            duty_next = duty_step;
            if (at_top)
                mode_next = fblr_pkg::MODE_FALLING;
            else if (duty_step[16])
                mode_next = fblr_pkg::MODE_RISING;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= fblr_pkg::MODE_RISING;
            duty_reg <= 17'd0;
            unit_reg <= fblr_pkg::UNIT_RESET;
            top_reg  <= fblr_pkg::TOP_RESET;
        end
        else
        begin
            mode_reg <= mode_next;
            duty_reg <= duty_next;
            unit_reg <= unit_next;
            top_reg  <= top_next;
        end
    end

    // post-update view, negative duty shown as zero
    assign view.duty    = duty_next[16] ? 16'd0 : duty_next[15:0];
    assign view.pwm_top = top_next;
    assign view.mode    = mode_next;

    `FBLR_ASSERT_NEXT(a_restart_zero, ctl.apply && (ctl.cmd == fblr_pkg::CMD_RESTART),
        (duty_reg == 17'd0) && (mode_reg == fblr_pkg::MODE_RISING),
        "restart frame did not clear the ramp")
    `FBLR_ASSERT_NEXT(a_dark_tick_zero,
        ctl.tick && !ctl.apply && (mode_reg == fblr_pkg::MODE_DARK),
        duty_reg == 17'd0, "dark tick left a nonzero duty")
    `FBLR_ASSERT_NEXT(a_idle_hold, !ctl.tick && !ctl.apply,
        $stable(duty_reg) && $stable(mode_reg) && $stable(top_reg),
        "ramp state moved without a request")

endmodule

### src/framed_led_breathing_ramp.sv
`timescale 1ns / 1ps
// Items are held in the item register, result beats in the result register.
// Throughput: one item per cycle unless the result stalls; the ramp state is
//   read and updated in the single stage between item and result registers.
// A stalled result holds the item register, which then stalls the input.
// Reset (rst_n low, asynchronous): rising mode, duty 0, period unit 1000,
//   PWM top 39999, frame counter cleared, both pipeline stages empty.
// ----------------------------------------------------------------------------
// framed_led_breathing_ramp
// Breathing-LED ramp controller fed by serial bytes (three-byte frames) and
// ramp ticks; gives one result beat for every item.
// ----------------------------------------------------------------------------
`include "framed_led_breathing_ramp_defines.svh"

module framed_led_breathing_ramp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  fblr_pkg::item_t      item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output fblr_pkg::result_t    result
);

    logic                 item_valid_reg;
    fblr_pkg::item_t      item_reg;
    logic                 result_valid_reg;
    fblr_pkg::result_t    result_reg, result_next;

    logic [1:0]           byte_count_reg, byte_count_next;
    logic [7:0]           first_byte_reg, first_byte_next;
    logic [7:0]           second_byte_reg, second_byte_next;

    logic                 advance;
    logic                 accept;
    logic                 is_byte;
    logic                 done;
    logic                 frame_ok;
    fblr_pkg::ramp_ctl_t  ctl;
    fblr_pkg::ramp_view_t view;

    // pipeline handshake
    assign advance    = item_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall = item_valid_reg && !advance;
    assign accept     = item_valid && !item_stall;

    // item register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (accept)
            item_valid_reg <= 1'b1;
        else if (advance)
            item_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item;
    end

    // frame assembly
    assign is_byte  = (item_reg.command == fblr_pkg::KIND_BYTE);
    assign done     = is_byte && byte_count_reg[1];
    assign frame_ok = done && (first_byte_reg == fblr_pkg::START_MARK);

    always_comb
    begin
        byte_count_next  = byte_count_reg;
        first_byte_next  = first_byte_reg;
        second_byte_next = second_byte_reg;
        if (advance && is_byte)
        begin
            case (byte_count_reg)
                2'd0:
                begin
                    first_byte_next = item_reg.byte_value;
                    byte_count_next = 2'd1;
                end
                2'd1:
                begin
                    second_byte_next = item_reg.byte_value;
                    byte_count_next  = 2'd2;
                end
                default:
                begin
                    byte_count_next = 2'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg  <= 2'd0;
            first_byte_reg  <= 8'd0;
            second_byte_reg <= 8'd0;
        end
        else
        begin
            byte_count_reg  <= byte_count_next;
            first_byte_reg  <= first_byte_next;
            second_byte_reg <= second_byte_next;
        end
    end

    // ramp update request
    assign ctl.tick  = advance && !is_byte;
    assign ctl.apply = advance && frame_ok;
    assign ctl.cmd   = second_byte_reg;
    assign ctl.data  = item_reg.byte_value;

    fblr_ramp u_ramp (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .view  (view)
    );

    // result beat
    always_comb
    begin
        result_next.duty           = view.duty;
        result_next.pwm_top        = view.pwm_top;
        result_next.mode           = view.mode;
        result_next.frame_done     = done;
        result_next.frame_accepted = frame_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (advance)
            result_valid_reg <= 1'b1;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `FBLR_ASSERT_NEXT(a_stall_freezes_frame, result_valid_reg && result_stall,
        $stable(byte_count_reg) && $stable(first_byte_reg),
        "frame state moved while the result was stalled")
    `FBLR_ASSERT_NEXT(a_frame_restart, advance && done, byte_count_reg == 2'd0,
        "frame counter did not restart after a third byte")
    `FBLR_ASSERT_NOW(a_accept_needs_done, result_valid_reg && result_reg.frame_accepted,
        result_reg.frame_done, "accepted frame without a completed frame")

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the framed breathing-LED ramp controller. A queue
// of byte and tick beats, starting with a directed opener and followed by
// random frames, stray bytes and tick runs, is driven with random gaps. The
// result side stalls at random. Each result beat is compared field by field
// against a cycle-free model of the ramp and framing state.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int RANDOM_ITEMS  = 1850;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        fblr_pkg::item_t beat;
        bit              drain;
    } pending_beat_t;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              item_valid   = 1'b0;
    logic              item_stall;
    fblr_pkg::item_t   item         = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    fblr_pkg::result_t result;

    pending_beat_t     pending_beats[$];
    fblr_pkg::result_t expected_results[$];
    int                total_items  = 0;
    int                results_seen = 0;
    int                mismatches   = 0;

    // ramp and framing state as the block should hold it
    logic [1:0]         pred_mode  = fblr_pkg::MODE_RISING;
    logic signed [16:0] pred_duty  = '0;
    logic [9:0]         pred_unit  = fblr_pkg::UNIT_RESET;
    logic [15:0]        pred_top   = fblr_pkg::TOP_RESET;
    logic [1:0]         pred_slot  = '0;
    logic [7:0]         pred_start = '0;
    logic [7:0]         pred_cmd   = '0;

    // driver and monitor scratch
    int                gap_left   = 0;
    int                send_calm  = 0;
    int                stall_left = 0;
    int                recv_calm  = 0;
    logic              next_valid;
    fblr_pkg::item_t   next_item;
    pending_beat_t     head_beat;
    fblr_pkg::result_t front_result;

    framed_led_breathing_ramp uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // single reset at the start
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // advance the ramp state by one beat and give the result it should show
    function automatic fblr_pkg::result_t ramp_predict(fblr_pkg::item_t beat);
        fblr_pkg::result_t r;
        int                bound;
        int                full;
        r = '0;
        if (beat.command == fblr_pkg::KIND_TICK)
        begin
            case (pred_mode)
                fblr_pkg::MODE_RISING:  pred_duty = pred_duty + fblr_pkg::STEP_SIZE;
                fblr_pkg::MODE_FALLING: pred_duty = pred_duty - fblr_pkg::STEP_SIZE;
                fblr_pkg::MODE_DARK:    pred_duty = '0;
                default:                ;
            endcase
            bound = int'(fblr_pkg::BOUND_MULT) * int'(pred_unit);
            if (int'(pred_duty) >= bound)
                pred_mode = fblr_pkg::MODE_FALLING;
            else if (pred_duty < 0)
                pred_mode = fblr_pkg::MODE_RISING;
        end
        else if (pred_slot == 2'd0)
        begin
            pred_start = beat.byte_value;
            pred_slot  = 2'd1;
        end
        else if (pred_slot == 2'd1)
        begin
            pred_cmd  = beat.byte_value;
            pred_slot = 2'd2;
        end
        else
        begin
            r.frame_done = 1'b1;
            pred_slot    = 2'd0;
            if (pred_start == fblr_pkg::START_MARK)
            begin
                r.frame_accepted = 1'b1;
                case (pred_cmd)
                    fblr_pkg::CMD_RESTART:
                    begin
                        pred_mode = fblr_pkg::MODE_RISING;
                        pred_duty = '0;
                    end
                    fblr_pkg::CMD_FALL:
                    begin
                        pred_mode = fblr_pkg::MODE_FALLING;
                        full      = int'(fblr_pkg::BOUND_MULT) * int'(pred_unit);
                        pred_duty = full[16:0];
                    end
                    fblr_pkg::CMD_DARK:
                        pred_mode = fblr_pkg::MODE_DARK;
                    default:
                        ;
                endcase
                pred_unit = {beat.byte_value, 2'b00};
                full      = int'(fblr_pkg::TOP_MULT) * int'(pred_unit);
                pred_top  = full[15:0];
            end
        end
        r.duty    = (pred_duty < 0) ? 16'd0 : pred_duty[15:0];
        r.pwm_top = pred_top;
        r.mode    = pred_mode;
        return r;
    endfunction

    // idle length: mostly short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic check_field(string label, int want, int got);
        if (want != got)
        begin
            $display("%0t mismatch on %s: expected %0d actual %0d", $time, label, want, got);
            mismatches++;
        end
    endtask

    task automatic add_beat(logic kind, logic [7:0] value, bit drain);
        pending_beat_t p;
        p.beat.command    = kind;
        p.beat.byte_value = value;
        p.drain           = drain;
        pending_beats.push_back(p);
    endtask

    task automatic add_frame(logic [7:0] start, logic [7:0] cmd, logic [7:0] data, bit drain);
        add_beat(fblr_pkg::KIND_BYTE, start, drain);
        add_beat(fblr_pkg::KIND_BYTE, cmd, 1'b0);
        add_beat(fblr_pkg::KIND_BYTE, data, 1'b0);
    endtask

    task automatic add_ticks(int count);
        repeat (count) add_beat(fblr_pkg::KIND_TICK, 8'($urandom_range(0, 255)), 1'b0);
    endtask

    // input driver: one beat at a time from the pending queue
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
            gap_left   = 0;
        end
        else
        begin
            next_valid = item_valid;
            next_item  = item;
            if (item_valid && !item_stall)
            begin
                expected_results.push_back(ramp_predict(item));
                next_valid = 1'b0;
                if (send_calm > 0)
                begin
                    send_calm--;
                    gap_left = 0;
                end
                else
                begin
                    gap_left = pick_gap();
                    if ($urandom_range(0, 49) == 0)
                        send_calm = $urandom_range(20, 80);
                end
            end
            if (!next_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_beats.size() > 0 &&
                         !(pending_beats[0].drain && expected_results.size() > 0))
                begin
                    head_beat  = pending_beats.pop_front();
                    next_item  = head_beat.beat;
                    next_valid = 1'b1;
                end
            end
            item_valid <= next_valid;
            item       <= next_item;
        end
    end

    // result monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left   = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t unexpected result beat: expected none actual %h",
                             $time, result);
                    mismatches++;
                end
                else
                begin
                    front_result = expected_results.pop_front();
                    check_field("duty", front_result.duty, result.duty);
                    check_field("pwm_top", front_result.pwm_top, result.pwm_top);
                    check_field("mode", front_result.mode, result.mode);
                    check_field("frame_done", front_result.frame_done, result.frame_done);
                    check_field("frame_accepted", front_result.frame_accepted,
                                result.frame_accepted);
                end
                results_seen++;
            end

            // stall bursts, with calm stretches in between
            if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= 1'b0;
                if (recv_calm > 0)
                    recv_calm--;
                else
                begin
                    stall_left = pick_gap();
                    if ($urandom_range(0, 63) == 0)
                        recv_calm = $urandom_range(30, 150);
                end
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        int         directed_count;
        int         pick;
        int         sel;
        bit         drain;
        bit         opening;
        logic [7:0] cmd;
        logic [7:0] data;

        // tick straight out of reset
        add_beat(fblr_pkg::KIND_TICK, 8'h00, 1'b0);
        // frame with a bad start byte is rejected
        add_frame(8'h7F, 8'hFF, 8'hFF, 1'b0);
        // restart with the widest period
        add_frame(fblr_pkg::START_MARK, fblr_pkg::CMD_RESTART, 8'hFF, 1'b0);
        add_beat(fblr_pkg::KIND_TICK, 8'hFF, 1'b0);
        // fall from the old bound, period drops to zero
        add_frame(fblr_pkg::START_MARK, fblr_pkg::CMD_FALL, 8'h00, 1'b0);
        add_beat(fblr_pkg::KIND_TICK, 8'hAA, 1'b0);
        // dark with zero period: tick forces zero and turns the ramp falling
        add_frame(fblr_pkg::START_MARK, fblr_pkg::CMD_DARK, 8'h00, 1'b0);
        add_beat(fblr_pkg::KIND_TICK, 8'h55, 1'b0);
        // unknown command keeps mode and duty, still sets the period
        add_frame(fblr_pkg::START_MARK, 8'h03, 8'h0A, 1'b0);
        // short ramp that bounces off the top and then goes below zero
        add_frame(fblr_pkg::START_MARK, fblr_pkg::CMD_RESTART, 8'h0A, 1'b0);
        add_ticks(5);
        directed_count = pending_beats.size();

        // random part, mostly well-formed frames followed by tick runs
        opening = 1'b1;
        while (pending_beats.size() < directed_count + RANDOM_ITEMS)
        begin
            drain   = opening || ($urandom_range(0, 99) < 2);
            opening = 1'b0;
            pick    = $urandom_range(0, 99);
            if (pick < 65)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 30)
                    cmd = fblr_pkg::CMD_RESTART;
                else if (sel < 55)
                    cmd = fblr_pkg::CMD_FALL;
                else if (sel < 70)
                    cmd = fblr_pkg::CMD_DARK;
                else
                    cmd = 8'($urandom_range(0, 255));
                sel = $urandom_range(0, 99);
                if (sel < 45)
                    data = 8'($urandom_range(0, 15));
                else if (sel < 85)
                    data = 8'($urandom_range(0, 255));
                else
                    data = sel[0] ? 8'hFF : 8'h00;
                add_frame(fblr_pkg::START_MARK, cmd, data, drain);
                add_ticks($urandom_range(0, 30));
            end
            else if (pick < 75)
            begin
                add_frame(8'($urandom_range(0, 254)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), drain);
            end
            else if (pick < 85)
            begin
                // stray byte shifts the frame alignment
                add_beat(fblr_pkg::KIND_BYTE, 8'($urandom_range(0, 255)), drain);
            end
            else
            begin
                add_beat(fblr_pkg::KIND_TICK, 8'($urandom_range(0, 255)), drain);
                add_ticks($urandom_range(0, 20));
            end
        end
        total_items = pending_beats.size();

        wait (rst_n === 1'b1);
        while (results_seen < total_items)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog: 10 ms is far beyond the slowest legal run
    initial
    begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
